>>> rtl/core/bfd_pkg.sv
// shared types and constants of the box filter downscaler
package bfd_pkg;

  localparam int LW_W     = 12;
  localparam int PIX_W    = 8;
  localparam int ROW_W    = 11;
  localparam int SUM_W    = 14;

  localparam int FACTOR_DEF         = 2;
  localparam int MAX_LINE_WIDTH_DEF = 2048;

  localparam logic [LW_W-1:0] LW_RESET = 12'd1920;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             start_of_frame;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_out_line;
  } pix_out_t;

  typedef struct packed {
    logic             valid;
    logic             first_line;
    logic             last_line;
    logic             eol;
    logic [ROW_W-1:0] row_sum;
  } band_req_t;

endpackage

>>> rtl/core/bfd_ram.sv
// generic single-port-write, single-port-read ram with registered read
module bfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bfd_ctrl.sv
// line position counters, row accumulator and groups per line register
module bfd_ctrl #(
  parameter int FACTOR         = bfd_pkg::FACTOR_DEF,
  parameter int MAX_LINE_WIDTH = bfd_pkg::MAX_LINE_WIDTH_DEF,
  localparam int IDX_W         = $clog2(MAX_LINE_WIDTH / FACTOR)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [bfd_pkg::LW_W-1:0] cfg_data_i,
  input  logic                     accept_i,
  input  bfd_pkg::pix_in_t         in_data_i,
  output bfd_pkg::band_req_t       req_o,
  output logic [IDX_W-1:0]         req_idx_o
);

  localparam int DEPTH  = MAX_LINE_WIDTH / FACTOR;
  localparam int GRP_W  = $clog2(DEPTH + 1);
  localparam int PH_W   = $clog2(FACTOR);
  localparam int SH     = bfd_pkg::LW_W + PH_W;
  localparam int RECIP  = ((1 << SH) + FACTOR - 1) / FACTOR;
  localparam int PROD_W = bfd_pkg::LW_W + SH + 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(FACTOR - 1);

  // groups per line: clamp, divide by factor, at least one
  function automatic logic [GRP_W-1:0] calc_groups(input logic [bfd_pkg::LW_W-1:0] lw);
    logic [bfd_pkg::LW_W-1:0] wc;
    logic [PROD_W-1:0]        prod;
    logic [GRP_W-1:0]         q;
    if (int'(lw) > MAX_LINE_WIDTH) begin
      wc = bfd_pkg::LW_W'(MAX_LINE_WIDTH);
    end else begin
      wc = lw;
    end
    prod = PROD_W'(wc) * PROD_W'(RECIP);
    q    = GRP_W'(prod >> SH);
    if (q == '0) begin
      q = GRP_W'(1);
    end
    return q;
  endfunction

  logic [PH_W-1:0]           p_q, p_d, p0;
  logic [GRP_W-1:0]          g_q, g_d, g0;
  logic [PH_W-1:0]           bp_q, bp_d, bp0;
  logic [bfd_pkg::ROW_W-1:0] acc_q, acc_d, acc0, acc_sum;
  logic [GRP_W-1:0]          q_q, q_d;
  logic [GRP_W:0]            g_inc;
  logic                      grp_end, line_end, sof;

  always_comb begin
    sof     = in_data_i.start_of_frame;
    p0      = sof ? '0 : p_q;
    g0      = sof ? '0 : g_q;
    bp0     = sof ? '0 : bp_q;
    acc0    = sof ? '0 : acc_q;
    acc_sum = acc0 + bfd_pkg::ROW_W'(in_data_i.pixel_in);
    grp_end = (p0 == PH_LAST);
    g_inc   = {1'b0, g0} + (GRP_W+1)'(1);
    line_end = (g0 >= q_q) || (grp_end && (g_inc >= {1'b0, q_q}));

    p_d   = p_q;
    g_d   = g_q;
    bp_d  = bp_q;
    acc_d = acc_q;
    if (accept_i) begin
      if (line_end) begin
        p_d   = '0;
        g_d   = '0;
        acc_d = '0;
        bp_d  = (bp0 == PH_LAST) ? '0 : bp0 + PH_W'(1);
      end else if (grp_end) begin
        p_d   = '0;
        g_d   = g_inc[GRP_W-1:0];
        acc_d = '0;
        bp_d  = bp0;
      end else begin
        p_d   = p0 + PH_W'(1);
        g_d   = g0;
        acc_d = acc_sum;
        bp_d  = bp0;
      end
    end

    q_d = cfg_valid_i ? calc_groups(cfg_data_i) : q_q;

    req_o.valid      = accept_i && grp_end;
    req_o.first_line = (bp0 == '0);
    req_o.last_line  = (bp0 == PH_LAST);
    req_o.eol        = line_end;
    req_o.row_sum    = acc_sum;
    req_idx_o        = g0[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q   <= '0;
      g_q   <= '0;
      bp_q  <= '0;
      acc_q <= '0;
      q_q   <= calc_groups(bfd_pkg::LW_RESET);
    end else begin
      p_q   <= p_d;
      g_q   <= g_d;
      bp_q  <= bp_d;
      acc_q <= acc_d;
      q_q   <= q_d;
    end
  end

endmodule

>>> rtl/core/bfd_band.sv
// band sum read-modify-write on the line store, divide and output register
module bfd_band #(
  parameter int FACTOR         = bfd_pkg::FACTOR_DEF,
  parameter int MAX_LINE_WIDTH = bfd_pkg::MAX_LINE_WIDTH_DEF,
  localparam int IDX_W         = $clog2(MAX_LINE_WIDTH / FACTOR)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bfd_pkg::band_req_t req_i,
  input  logic [IDX_W-1:0]   req_idx_i,
  output logic               busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bfd_pkg::pix_out_t  out_data_o
);

  localparam int DEPTH   = MAX_LINE_WIDTH / FACTOR;
  localparam int DIV     = FACTOR * FACTOR;
  localparam int DV_W    = $clog2(DIV);
  localparam int SH2     = bfd_pkg::SUM_W + DV_W;
  localparam int RECIP2  = ((1 << SH2) + DIV - 1) / DIV;
  localparam int PROD2_W = bfd_pkg::SUM_W + SH2 + 1;

  logic                      rd_en, wr_en;
  logic [bfd_pkg::SUM_W-1:0] rd_data, sum1;
  logic                      v1_q, v2_q, out_v_q;
  bfd_pkg::band_req_t        req1_q;
  logic [IDX_W-1:0]          idx1_q;
  logic [bfd_pkg::SUM_W-1:0] sum2_q;
  logic                      eol2_q;
  bfd_pkg::pix_out_t         out_q;
  logic [PROD2_W-1:0]        prod2;
  logic                      out_free, s2_free, s1_free;

  assign rd_en = req_i.valid && !req_i.first_line;

  bfd_ram #(
    .WIDTH (bfd_pkg::SUM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (idx1_q),
    .wdata_i (sum1),
    .re_i    (rd_en),
    .raddr_i (req_idx_i),
    .rdata_o (rd_data)
  );

  always_comb begin
    out_free = !out_v_q || !out_stall_i;
    s2_free  = !v2_q || out_free;
    s1_free  = !v1_q || !req1_q.last_line || s2_free;
    busy_o   = !s1_free;
    sum1     = bfd_pkg::SUM_W'(req1_q.row_sum) + (req1_q.first_line ? '0 : rd_data);
    wr_en    = v1_q && !req1_q.last_line;
    prod2    = PROD2_W'(sum2_q) * PROD2_W'(RECIP2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_q <= req_i.valid;
      end
      if (s2_free) begin
        v2_q <= v1_q && req1_q.last_line;
      end
      if (out_free) begin
        out_v_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      req1_q <= req_i;
      idx1_q <= req_idx_i;
    end
    if (s2_free) begin
      sum2_q <= sum1;
      eol2_q <= req1_q.eol;
    end
    if (out_free) begin
      out_q.pixel_out       <= bfd_pkg::PIX_W'(prod2 >> SH2);
      out_q.end_of_out_line <= eol2_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/core/box_filter_downscaler.sv
// box filter downscaler top level
// a beat that closes a square is registered through the request, band sum and output stages before its output beat
// throughput: one pixel beat per cycle unless in_stall_o is raised, one line store access per pixel group
// reset: clears counters and row accumulator, line width returns to 1920
// line store contents are undefined after reset, no clearing pass is run
module box_filter_downscaler #(
  parameter int FACTOR         = bfd_pkg::FACTOR_DEF,
  parameter int MAX_LINE_WIDTH = bfd_pkg::MAX_LINE_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [bfd_pkg::LW_W-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  bfd_pkg::pix_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output bfd_pkg::pix_out_t        out_data_o
);

  localparam int IDX_W = $clog2(MAX_LINE_WIDTH / FACTOR);

  bfd_pkg::band_req_t req;
  logic [IDX_W-1:0]   req_idx;
  logic               busy;
  logic               accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign accept      = in_valid_i && !busy;

  bfd_ctrl #(
    .FACTOR         (FACTOR),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .req_o       (req),
    .req_idx_o   (req_idx)
  );

  bfd_band #(
    .FACTOR         (FACTOR),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_band (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_idx_i   (req_idx),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/box_filter_downscaler_test.sv
// testbench of the box filter downscaler: random raster frames checked against a box mean predictor
`timescale 1ns / 100ps

module box_filter_downscaler_test;

  localparam int FACTOR         = bfd_pkg::FACTOR_DEF;
  localparam int MAX_WIDTH      = bfd_pkg::MAX_LINE_WIDTH_DEF;
  localparam int STORE_DEPTH    = MAX_WIDTH / 2;
  localparam int RANDOM_PIXELS  = 400;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 300;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [bfd_pkg::LW_W-1:0] cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  bfd_pkg::pix_in_t         in_data_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  bfd_pkg::pix_out_t        out_data_o;

  box_filter_downscaler #(
    .FACTOR(FACTOR),
    .MAX_LINE_WIDTH(MAX_WIDTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  // line width as last written, shared by stimulus planning and prediction
  logic [bfd_pkg::LW_W-1:0]  line_width_q = bfd_pkg::LW_RESET;

  // predictor state
  int unsigned               col_q = 0;
  int unsigned               band_phase_q = 0;
  int unsigned               row_sum_q = 0;
  logic [bfd_pkg::SUM_W-1:0] band_sums [STORE_DEPTH];
  bfd_pkg::pix_out_t         expected_means[$];

  // stimulus planning state, tracks which band sums hold data
  int unsigned               plan_col = 0;
  int unsigned               plan_phase = 0;
  bit                        plan_written [STORE_DEPTH];
  bfd_pkg::pix_in_t          pending_pixels[$];

  int                        errors = 0;
  int                        cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_width(input logic [bfd_pkg::LW_W-1:0] lw);
    int unsigned w;
    w = lw;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    w -= w % FACTOR;
    if (w < FACTOR) w = FACTOR;
    return w;
  endfunction

  function automatic void predict_box_mean(input bfd_pkg::pix_in_t beat);
    int unsigned       w;
    int unsigned       idx;
    int unsigned       sum;
    bfd_pkg::pix_out_t mean;
    w = active_width(line_width_q);
    if (beat.start_of_frame) begin
      col_q = 0;
      band_phase_q = 0;
      row_sum_q = 0;
    end
    row_sum_q = (row_sum_q + beat.pixel_in) & 32'h7FF;
    if (col_q % FACTOR == FACTOR - 1) begin
      idx = (col_q / FACTOR) % STORE_DEPTH;
      sum = row_sum_q;
      if (band_phase_q != 0) sum += band_sums[idx];
      sum &= 32'h3FFF;
      if (band_phase_q >= FACTOR - 1) begin
        mean.pixel_out = 8'(sum / (FACTOR * FACTOR));
        mean.end_of_out_line = (col_q + 1 >= w);
        expected_means.push_back(mean);
      end else begin
        band_sums[idx] = bfd_pkg::SUM_W'(sum);
      end
      row_sum_q = 0;
    end
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_sum_q = 0;
      band_phase_q++;
      if (band_phase_q >= FACTOR) band_phase_q = 0;
    end
  endfunction

  // a pixel that would read a never written band sum starts a new frame instead
  function automatic void queue_pixel(input logic [bfd_pkg::PIX_W-1:0] pix, input logic sof);
    int unsigned      w;
    bfd_pkg::pix_in_t beat;
    w = active_width(line_width_q);
    if (sof) begin
      plan_col = 0;
      plan_phase = 0;
    end
    if (plan_col % FACTOR == FACTOR - 1 && plan_phase != 0 &&
        !plan_written[(plan_col / FACTOR) % STORE_DEPTH]) begin
      sof = 1'b1;
      plan_col = 0;
      plan_phase = 0;
    end
    if (plan_col % FACTOR == FACTOR - 1 && plan_phase == 0)
      plan_written[(plan_col / FACTOR) % STORE_DEPTH] = 1'b1;
    plan_col++;
    if (plan_col >= w) begin
      plan_col = 0;
      plan_phase++;
      if (plan_phase >= FACTOR) plan_phase = 0;
    end
    beat.pixel_in = pix;
    beat.start_of_frame = sof;
    pending_pixels.push_back(beat);
  endfunction

  function automatic void queue_pixels(input int count, input bit lead_sof);
    int          k;
    int unsigned pick;
    logic [7:0]  pix;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) pix = 8'h00;
      else if (pick == 1) pix = 8'hFF;
      else pix = 8'($urandom_range(0, 255));
      queue_pixel(pix, (k == 0 && lead_sof) || $urandom_range(0, 99) == 0);
    end
  endfunction

  task automatic write_line_width(input logic [bfd_pkg::LW_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    line_width_q = value;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_pixels.size() != 0 || in_valid_i || expected_means.size() != 0)
      @(negedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // pixel sender, bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_box_mean(in_data_i);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = $urandom_range(1, 40);
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_pixels.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output receiver with its own stall pattern and long hold-offs
  int hold_left = 0;
  int stall_run = 0;
  int out_beats = 0;
  int next_hold_at = 20;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) out_beats++;
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_beats >= next_hold_at && pending_pixels.size() >= 40) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += 60;
        out_stall_i <= 1'b1;
      end else if (stall_run != 0) begin
        stall_run--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_run = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 7);
        out_stall_i <= 1'b0;
      end
    end
  end

  bfd_pkg::pix_out_t want_beat;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_means.size() == 0) begin
        $display("%0t: output beat with none expected, got %0h", $time, out_data_o);
        errors++;
      end else begin
        want_beat = expected_means.pop_front();
        if (out_data_o.pixel_out !== want_beat.pixel_out) begin
          $display("%0t: pixel_out expected %0d actual %0d",
                   $time, want_beat.pixel_out, out_data_o.pixel_out);
          errors++;
        end
        if (out_data_o.end_of_out_line !== want_beat.end_of_out_line) begin
          $display("%0t: end_of_out_line expected %0b actual %0b",
                   $time, want_beat.end_of_out_line, out_data_o.end_of_out_line);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  logic [8:0] line_1920_pixels [8] = '{
    {8'hFF, 1'b1}, {8'h00, 1'b0}, {8'hAA, 1'b0}, {8'h55, 1'b0},
    {8'h01, 1'b0}, {8'h80, 1'b0}, {8'hFE, 1'b0}, {8'h7F, 1'b0}
  };
  logic [8:0] width_2_pixels [19] = '{
    {8'd200, 1'b0}, {8'd255, 1'b1}, {8'd255, 1'b0}, {8'd255, 1'b0}, {8'd255, 1'b0},
    {8'd0, 1'b0}, {8'd0, 1'b0}, {8'd0, 1'b0}, {8'd0, 1'b0},
    {8'd1, 1'b0}, {8'd1, 1'b0}, {8'd1, 1'b0}, {8'd0, 1'b0},
    {8'd3, 1'b0}, {8'd3, 1'b0}, {8'd3, 1'b0}, {8'd2, 1'b0},
    {8'd7, 1'b1}, {8'd9, 1'b0}
  };

  initial begin
    int                       k;
    int                       random_items;
    int                       count;
    int unsigned              pick;
    int unsigned              eff;
    logic [bfd_pkg::LW_W-1:0] width;

    random_items = 0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset width, first line of a band gives no output
    for (k = 0; k < 8; k++)
      queue_pixel(line_1920_pixels[k][8:1], line_1920_pixels[k][0]);
    wait_drained();

    // narrowest width, line ends early after the width shrinks mid-line
    write_line_width(bfd_pkg::LW_W'(2));
    for (k = 0; k < 19; k++)
      queue_pixel(width_2_pixels[k][8:1], width_2_pixels[k][0]);
    wait_drained();

    // top of the register range, clamped to the widest line
    write_line_width(bfd_pkg::LW_W'(4095));
    queue_pixels(64, 1'b1);
    wait_drained();

    write_line_width(bfd_pkg::LW_W'(0));
    queue_pixels(8, 1'b1);
    wait_drained();
    write_line_width(bfd_pkg::LW_W'(1));
    queue_pixels(6, 1'b0);
    wait_drained();
    write_line_width(bfd_pkg::LW_W'(3));
    queue_pixels(9, 1'b1);
    wait_drained();
    write_line_width(bfd_pkg::LW_W'(2048));
    queue_pixels(100, 1'b0);
    wait_drained();
    write_line_width(bfd_pkg::LW_W'(2047));
    queue_pixels(80, 1'b0);
    wait_drained();

    while (random_items < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) width = bfd_pkg::LW_W'($urandom_range(0, 4095));
      else if (pick == 1) width = bfd_pkg::LW_W'($urandom_range(0, 1));
      else width = bfd_pkg::LW_W'($urandom_range(2, 40));
      write_line_width(width);
      eff = active_width(width);
      if (eff > 64) begin
        count = $urandom_range(10, 150);
      end else begin
        count = eff * $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) count += $urandom_range(0, eff);
      end
      queue_pixels(count, $urandom_range(0, 3) != 0);
      random_items += count;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0 && expected_means.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
